### rtl/core/mrc_pkg.sv
`timescale 1ns / 1ps
package mrc_pkg;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [7:0]  ERR_MARK = 8'h0E;

   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   typedef struct packed {
      logic       done;
      logic       ok;
      logic [7:0] value;
   } frame_evt_type;

   typedef struct packed {
      logic       is_read;
      logic [3:0] slot;
      logic [7:0] value;
      logic       crc_ok;
      logic       cleared;
   } rsp_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

### rtl/core/mrc_frame.sv
`timescale 1ns / 1ps
module mrc_frame
   import mrc_pkg::*;
#(
   parameter int FRAME_LEN  = 13,
   parameter int SAMPLE_POS = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          byte_en,
   input  logic          frame_start,
   input  logic [7:0]    rx_byte,
   output frame_evt_type evt
);

   localparam int CW = $clog2(FRAME_LEN);

   logic [CW-1:0] cnt_ff, cnt_in, cnt_cur;
   logic [15:0]   crc_ff, crc_in, crc_cur, crc_next;
   logic [7:0]    smp_ff, smp_in;
   logic          last;

   always_comb begin
      cnt_cur  = frame_start ? '0 : cnt_ff;
      crc_cur  = frame_start ? CRC_INIT : crc_ff;
      crc_next = crc_byte(crc_cur, rx_byte);
      last     = (32'(cnt_cur) == FRAME_LEN - 1);
      smp_in   = (32'(cnt_cur) == SAMPLE_POS) ? rx_byte : smp_ff;
      cnt_in   = last ? '0 : CW'(cnt_cur + 1'b1);
      crc_in   = last ? CRC_INIT : crc_next;

      evt.done  = byte_en && last;
      evt.ok    = (crc_next == 16'h0000);
      evt.value = evt.ok ? smp_in : ERR_MARK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         crc_ff <= CRC_INIT;
         smp_ff <= '0;
      end else if (byte_en) begin
         cnt_ff <= cnt_in;
         crc_ff <= crc_in;
         smp_ff <= smp_in;
      end
   end

endmodule

### rtl/core/modbus_response_check_store_top.sv
`timescale 1ns / 1ps
// modbus rtu response checker with sample store
// request channel: req_valid/req_ready with req_func, req_frame_start,
//   req_rx_byte, req_read_index. func byte feeds one response byte, func read
//   fetches one store slot
// response channel: rsp_valid/rsp_ready with rsp_is_read, rsp_slot,
//   rsp_value, rsp_crc_ok, rsp_store_cleared
// a read gives one response; a byte gives one only when it ends a frame
// path: a taken request is registered in the stage register alongside the
//   synchronous store read, then moves on into the output register
// throughput: one request per cycle while req_ready is high, set by the single
//   store port and the one-byte-per-cycle crc update
// reset: synchronous, clears the byte count, crc, captured sample, write slot
//   and the per-slot valid bits, so every slot reads as zero at once
// stall: while rsp_ready is low the output and one staged response are held;
//   req_ready drops only when both are full
module modbus_response_check_store_top
   import mrc_pkg::*;
#(
   parameter int FRAME_LEN   = 13,
   parameter int SAMPLE_POS  = 8,
   parameter int STORE_DEPTH = 13
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_func,
   input  logic       req_frame_start,
   input  logic [7:0] req_rx_byte,
   input  logic [3:0] req_read_index,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_is_read,
   output logic [3:0] rsp_slot,
   output logic [7:0] rsp_value,
   output logic       rsp_crc_ok,
   output logic       rsp_store_cleared
);

   localparam int SW = $clog2(STORE_DEPTH);

   logic [7:0]             mem [STORE_DEPTH];
   logic [STORE_DEPTH-1:0] vld_ff, vld_in;
   logic [SW-1:0]          ws_ff, ws_in;
   logic [SW-1:0]          raddr;
   logic [7:0]             rd_ff;
   logic                   rdv_ff;
   logic                   s1_valid_ff, s1_valid_in;
   rsp_type                s1_ff, s1_in;
   logic                   out_valid_ff, out_valid_in;
   rsp_type                out_ff, out_in;
   logic                   req_fire, out_free, byte_en, rd_en, wr_en, wrap;
   frame_evt_type          evt;

   mrc_frame #(
      .FRAME_LEN (FRAME_LEN),
      .SAMPLE_POS(SAMPLE_POS)
   ) u_frame (
      .clock      (clock),
      .reset      (reset),
      .byte_en    (byte_en),
      .frame_start(req_frame_start),
      .rx_byte    (req_rx_byte),
      .evt        (evt)
   );

   always_comb begin
      out_free  = !out_valid_ff || rsp_ready;
      req_ready = !s1_valid_ff || out_free;
      req_fire  = req_valid && req_ready;
      byte_en   = req_fire && (req_func == FUNC_BYTE);
      rd_en     = req_fire && (req_func == FUNC_READ);
      wr_en     = evt.done;
      wrap      = (32'(ws_ff) == STORE_DEPTH - 1);
      raddr     = SW'(req_read_index);

      vld_in = vld_ff;
      ws_in  = ws_ff;
      if (wr_en) begin
         if (wrap) begin
            vld_in = '0;
            ws_in  = '0;
         end else begin
            vld_in[ws_ff] = 1'b1;
            ws_in         = SW'(ws_ff + 1'b1);
         end
      end

      s1_in       = s1_ff;
      s1_valid_in = s1_valid_ff;
      if (req_ready) begin
         s1_valid_in = rd_en || wr_en;
         if (rd_en) begin
            s1_in.is_read = 1'b1;
            s1_in.slot    = req_read_index;
            s1_in.value   = '0;
            s1_in.crc_ok  = 1'b0;
            s1_in.cleared = 1'b0;
         end else begin
            s1_in.is_read = 1'b0;
            s1_in.slot    = 4'(ws_ff);
            s1_in.value   = evt.value;
            s1_in.crc_ok  = evt.ok;
            s1_in.cleared = wrap;
         end
      end

      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = s1_valid_ff;
         out_in       = s1_ff;
         if (s1_ff.is_read) begin
            out_in.value = rdv_ff ? rd_ff : 8'h00;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && !wrap) begin
         mem[ws_ff] <= evt.value;
      end
      if (rd_en) begin
         rd_ff  <= mem[raddr];
         rdv_ff <= (32'(req_read_index) < STORE_DEPTH) && vld_ff[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         ws_ff        <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= vld_in;
         ws_ff        <= ws_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      out_ff <= out_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_is_read       = out_ff.is_read;
   assign rsp_slot          = out_ff.slot;
   assign rsp_value         = out_ff.value;
   assign rsp_crc_ok        = out_ff.crc_ok;
   assign rsp_store_cleared = out_ff.cleared;

endmodule

### rtl/core/mrc_check.sv
`timescale 1ns / 1ps
module mrc_check #(
   parameter int STORE_DEPTH = 13
) (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_is_read,
   input logic [3:0] rsp_slot,
   input logic [7:0] rsp_value,
   input logic       rsp_crc_ok,
   input logic       rsp_store_cleared
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_slot))
      else $error("response changed while stalled");

   a_read_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_read |-> !rsp_crc_ok && !rsp_store_cleared)
      else $error("read response carries frame flags");

   a_read_past: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_read && (32'(rsp_slot) >= STORE_DEPTH) |-> rsp_value == 8'h00)
      else $error("read past store not zero");

   a_clear_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_read && rsp_store_cleared |-> rsp_slot == 4'(STORE_DEPTH - 1))
      else $error("store cleared on wrong slot");

   a_reset_idle: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind modbus_response_check_store_top mrc_check #(.STORE_DEPTH(STORE_DEPTH)) u_mrc_check (.*);
